@@ rtl/core/bcd_pkg.sv @@
// shared types, codes and arithmetic helpers for the block decoder
`default_nettype none

package bcd_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int BLK_W   = 10;
  localparam int CNT_W   = 11;
  localparam int COORD_W = 12;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [63:0]      color_word;
    logic [63:0]      alpha_word;
    logic [1:0]       fmt;
    logic [BLK_W-1:0] col;
    logic [BLK_W-1:0] row;
    logic             last_block;
    logic [1:0]       x_last;
    logic [1:0]       y_last;
  } job_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef struct packed {
    rgba_t [3:0]     color;
    logic [7:0][7:0] alpha;
  } palette_t;

  // v*255/31 truncated, by reciprocal
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'd255 * 32'd8457;
    return p[25:18];
  endfunction

  // v*255/63 truncated, by reciprocal
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'd255 * 32'd16645;
    return p[27:20];
  endfunction

  // exact for x below 768, where the quotient fits in eight bits
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd2341;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd3277;
    return p[21:14];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bcd_front.sv @@
// input side: configuration registers, alpha hold, block counters and job register
`default_nettype none

module bcd_front
  import bcd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire logic             word_valid,
  output logic                  word_ready,
  input  wire logic [63:0]      data_word,
  input  wire logic             take,
  output logic                  job_valid,
  output job_t                  job
);

  logic [1:0]       texture_format;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [BLK_W-1:0] block_column;
  logic [BLK_W-1:0] block_row;
  logic             alpha_pending;
  logic [63:0]      held_alpha_word;

  logic             has_alpha;
  logic             alpha_item;
  logic             accept;
  logic [DIM_W-1:0] wd_c;
  logic [DIM_W-1:0] ht_c;
  logic [DIM_W-1:0] wsum;
  logic [DIM_W-1:0] hsum;
  logic [CNT_W-1:0] bcx;
  logic [CNT_W-1:0] bcy;
  logic             wrap_c;
  logic [CNT_W-1:0] col_e;
  logic [CNT_W-1:0] row_t;
  logic [CNT_W-1:0] row_e;
  logic [CNT_W-1:0] col_n;
  logic [CNT_W-1:0] row_n;
  logic [DIM_W-1:0] x_rem;
  logic [DIM_W-1:0] y_rem;
  job_t             job_next;

  always_comb begin
    has_alpha  = (texture_format == FMT_DXT3) || (texture_format == FMT_DXT5);
    alpha_item = has_alpha && !alpha_pending;
    word_ready = alpha_item || !job_valid || take;
    accept     = word_valid && word_ready;

    if (image_width == '0) begin
      wd_c = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_DIM)) begin
      wd_c = DIM_W'(MAX_DIM);
    end else begin
      wd_c = image_width;
    end
    if (image_height == '0) begin
      ht_c = DIM_W'(1);
    end else if (image_height > DIM_W'(MAX_DIM)) begin
      ht_c = DIM_W'(MAX_DIM);
    end else begin
      ht_c = image_height;
    end
    wsum = wd_c + DIM_W'(3);
    hsum = ht_c + DIM_W'(3);
    bcx  = wsum[DIM_W-1:2];
    bcy  = hsum[DIM_W-1:2];

    // counters left out of range by a size change wrap first
    wrap_c = {1'b0, block_column} >= bcx;
    col_e  = wrap_c ? '0 : {1'b0, block_column};
    row_t  = wrap_c ? {1'b0, block_row} + CNT_W'(1) : {1'b0, block_row};
    row_e  = (row_t >= bcy) ? '0 : row_t;
    col_n  = col_e + CNT_W'(1);
    row_n  = row_e + CNT_W'(1);

    x_rem = wd_c - {1'b0, col_e[BLK_W-1:0], 2'b00};
    y_rem = ht_c - {1'b0, row_e[BLK_W-1:0], 2'b00};

    job_next.color_word = data_word;
    job_next.alpha_word = held_alpha_word;
    job_next.fmt        = texture_format;
    job_next.col        = col_e[BLK_W-1:0];
    job_next.row        = row_e[BLK_W-1:0];
    job_next.last_block = (col_e == bcx - CNT_W'(1)) && (row_e == bcy - CNT_W'(1));
    job_next.x_last     = (x_rem >= DIM_W'(4)) ? 2'd3 : x_rem[1:0] - 2'd1;
    job_next.y_last     = (y_rem >= DIM_W'(4)) ? 2'd3 : y_rem[1:0] - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= FMT_DXT1;
      image_width    <= DIM_W'(4);
      image_height   <= DIM_W'(4);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FORMAT: texture_format <= cfg_data[1:0];
        CFG_WIDTH:  image_width    <= cfg_data;
        CFG_HEIGHT: image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column  <= '0;
      block_row     <= '0;
      alpha_pending <= 1'b0;
      job_valid     <= 1'b0;
    end else begin
      if (accept && alpha_item) begin
        alpha_pending <= 1'b1;
      end else if (accept) begin
        alpha_pending <= 1'b0;
        if (col_n >= bcx) begin
          block_column <= '0;
          block_row    <= (row_n >= bcy) ? '0 : row_n[BLK_W-1:0];
        end else begin
          block_column <= col_n[BLK_W-1:0];
          block_row    <= row_e[BLK_W-1:0];
        end
      end
      // an alpha item may arrive in the same cycle as the job is taken
      if (accept && !alpha_item) begin
        job_valid <= 1'b1;
      end else if (take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && alpha_item) begin
      held_alpha_word <= data_word;
    end
    if (accept && !alpha_item) begin
      job <= job_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bcd_palette.sv @@
// colour and alpha palettes of one block
`default_nettype none

module bcd_palette
  import bcd_pkg::*;
(
  input  job_t     job,
  output palette_t pal
);

  logic [15:0]  c0;
  logic [15:0]  c1;
  logic         four;
  logic [7:0]   a0;
  logic [7:0]   a1;
  logic [10:0]  acc;
  rgba_t        e0;
  rgba_t        e1;

  always_comb begin
    c0   = job.color_word[15:0];
    c1   = job.color_word[31:16];
    four = (job.fmt == FMT_DXT3) || (job.fmt == FMT_DXT5) || (c0 > c1);

    e0.r = expand5(c0[15:11]);
    e0.g = expand6(c0[10:5]);
    e0.b = expand5(c0[4:0]);
    e0.a = 8'd255;
    e1.r = expand5(c1[15:11]);
    e1.g = expand6(c1[10:5]);
    e1.b = expand5(c1[4:0]);
    e1.a = 8'd255;

    pal.color[0] = e0;
    pal.color[1] = e1;
    if (four) begin
      pal.color[2].r = div3({1'b0, e0.r, 1'b0} + {2'b00, e1.r});
      pal.color[2].g = div3({1'b0, e0.g, 1'b0} + {2'b00, e1.g});
      pal.color[2].b = div3({1'b0, e0.b, 1'b0} + {2'b00, e1.b});
      pal.color[2].a = 8'd255;
      pal.color[3].r = div3({2'b00, e0.r} + {1'b0, e1.r, 1'b0});
      pal.color[3].g = div3({2'b00, e0.g} + {1'b0, e1.g, 1'b0});
      pal.color[3].b = div3({2'b00, e0.b} + {1'b0, e1.b, 1'b0});
      pal.color[3].a = 8'd255;
    end else begin
      // three colours plus transparent black
      pal.color[2].r = 8'(({1'b0, e0.r} + {1'b0, e1.r}) >> 1);
      pal.color[2].g = 8'(({1'b0, e0.g} + {1'b0, e1.g}) >> 1);
      pal.color[2].b = 8'(({1'b0, e0.b} + {1'b0, e1.b}) >> 1);
      pal.color[2].a = 8'd255;
      pal.color[3]   = '0;
    end

    a0 = job.alpha_word[7:0];
    a1 = job.alpha_word[15:8];
    pal.alpha[0] = a0;
    pal.alpha[1] = a1;
    acc = '0;
    for (int k = 2; k < 8; k++) begin
      if (a0 > a1) begin
        acc = 11'(8 - k) * {3'b000, a0} + 11'(k - 1) * {3'b000, a1};
        pal.alpha[k] = div7(acc);
      end else if (k == 6) begin
        pal.alpha[k] = 8'd0;
      end else if (k == 7) begin
        pal.alpha[k] = 8'd255;
      end else begin
        acc = 11'(6 - k) * {3'b000, a0} + 11'(k - 1) * {3'b000, a1};
        pal.alpha[k] = div5(acc);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bcd_emitter.sv @@
// palette register, pixel walker and output register
`default_nettype none

module bcd_emitter
  import bcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  input  job_t                    job,
  input  palette_t                pal_in,
  output logic                    take,
  output logic                    pixel_valid,
  input  wire logic               pixel_ready,
  output logic [COORD_W-1:0]      pixel_x,
  output logic [COORD_W-1:0]      pixel_y,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic [7:0]              alpha,
  output logic                    block_last,
  output logic                    image_last
);

  logic             busy;
  palette_t         pal;
  logic [31:0]      cidx;
  logic [63:0]      aw;
  logic [1:0]       fmt;
  logic [BLK_W-1:0] col;
  logic [BLK_W-1:0] row;
  logic             last_block;
  logic [1:0]       x_last;
  logic [1:0]       y_last;
  logic [1:0]       xi;
  logic [1:0]       yi;

  logic             emit;
  logic             end_pix;
  logic             last_step;
  logic [3:0]       pi;
  logic [1:0]       ci;
  logic [3:0]       nib;
  logic [5:0]       a_off;
  logic [2:0]       ai;
  rgba_t            c_sel;
  logic [7:0]       a_sel;

  always_comb begin
    emit      = busy && (!pixel_valid || pixel_ready);
    end_pix   = (xi == x_last) && (yi == y_last);
    last_step = emit && end_pix;
    take      = job_valid && (!busy || last_step);

    pi    = {yi, xi};
    ci    = cidx[{pi, 1'b0} +: 2];
    nib   = aw[{pi, 2'b00} +: 4];
    a_off = 6'd16 + 6'({2'b00, pi} * 6'd3);
    ai    = aw[a_off +: 3];
    c_sel = pal.color[ci];
    case (fmt)
      FMT_DXT3: a_sel = {nib, nib};
      FMT_DXT5: a_sel = pal.alpha[ai];
      default:  a_sel = c_sel.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
      end else if (last_step) begin
        busy <= 1'b0;
      end
      if (emit) begin
        pixel_valid <= 1'b1;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pal        <= pal_in;
      cidx       <= job.color_word[63:32];
      aw         <= job.alpha_word;
      fmt        <= job.fmt;
      col        <= job.col;
      row        <= job.row;
      last_block <= job.last_block;
      x_last     <= job.x_last;
      y_last     <= job.y_last;
      xi         <= 2'd0;
      yi         <= 2'd0;
    end else if (emit) begin
      // walk only the pixels inside the image, row by row
      if (xi == x_last) begin
        xi <= 2'd0;
        yi <= yi + 2'd1;
      end else begin
        xi <= xi + 2'd1;
      end
    end
    if (emit) begin
      pixel_x    <= {col, xi};
      pixel_y    <= {row, yi};
      red        <= c_sel.r;
      green      <= c_sel.g;
      blue       <= c_sel.b;
      alpha      <= a_sel;
      block_last <= end_pix;
      image_last <= end_pix && last_block;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bc1_bc2_bc3_block_decoder_unit.sv @@
// top level of the bc1/bc2/bc3 block decoder
//
// usage:
//   configuration is a plain write port (cfg_write, cfg_index, cfg_data):
//   index 0 texture format, 1 image width, 2 image height; write only while idle
//   compressed words enter on word_valid/word_ready, blocks in raster order;
//   in dxt3/dxt5 the alpha word of a block comes first, then its colour word
//   pixels leave on pixel_valid/pixel_ready, one item per decoded pixel,
//   row-major inside the block, cropped at the right and bottom edges
// path: a taken colour word passes the job register, the palette register and
//   the output register before its first pixel is shown; an alpha word gives no pixels and is taken at once
// throughput: one pixel a cycle while a job waits and pixel_ready is high, set by
//   the single pixel walker; the next colour word waits in a job register while a
//   block is walked
// reset: all counters back to block zero, dxt1, 4x4 image, pipeline empty
// stall: a held pixel_ready low freezes the output register and the walker;
//   one further colour word can still be taken into the job register
`default_nettype none

module bc1_bc2_bc3_block_decoder_unit
  import bcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [DIM_W-1:0]   cfg_data,
  input  wire logic               word_valid,
  output logic                    word_ready,
  input  wire logic [63:0]        data_word,
  output logic                    pixel_valid,
  input  wire logic               pixel_ready,
  output logic [COORD_W-1:0]      pixel_x,
  output logic [COORD_W-1:0]      pixel_y,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic [7:0]              alpha,
  output logic                    block_last,
  output logic                    image_last
);

  logic     job_valid;
  logic     take;
  job_t     job;
  palette_t pal;

  bcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .data_word  (data_word),
    .take       (take),
    .job_valid  (job_valid),
    .job        (job)
  );

  bcd_palette u_palette (
    .job (job),
    .pal (pal)
  );

  bcd_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .pal_in      (pal),
    .take        (take),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .block_last  (block_last),
    .image_last  (image_last)
  );

endmodule

`default_nettype wire

@@ rtl/core/bcd_checker.sv @@
// port-level checks for the block decoder, bound to the top level
`default_nettype none

module bcd_checker
  import bcd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               word_ready,
  input wire logic               pixel_valid,
  input wire logic               pixel_ready,
  input wire logic [COORD_W-1:0] pixel_x,
  input wire logic [COORD_W-1:0] pixel_y,
  input wire logic [7:0]         red,
  input wire logic [7:0]         green,
  input wire logic [7:0]         blue,
  input wire logic [7:0]         alpha,
  input wire logic               block_last,
  input wire logic               image_last
);

  // nothing is left in flight after reset
  a_reset_empty : assert property (@(posedge clk) rst |=> !pixel_valid && word_ready)
    else $error("pipeline not empty after reset");

  // a stalled pixel holds still
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha)
      && $stable(block_last) && $stable(image_last))
    else $error("stalled pixel changed");

  // end of image only ever closes a block
  a_image_block : assert property (@(posedge clk) disable iff (rst)
    pixel_valid && image_last |-> block_last)
    else $error("image end without block end");

  // a word taken on leaving reset must pass the job, palette and output registers
  a_min_latency : assert property (@(posedge clk) rst ##1 !rst |=> !pixel_valid)
    else $error("pixel shown too early");

endmodule

bind bc1_bc2_bc3_block_decoder_unit bcd_checker u_checker (.*);

`default_nettype wire
